>>> design/kft_pkg.sv
package kft_pkg;
  localparam int MAX_FRAME_BYTES_DEF = 1024;
  localparam logic [7:0] KISS_FEND  = 8'hC0;
  localparam logic [7:0] KISS_FESC  = 8'hDB;
  localparam logic [7:0] KISS_TFEND = 8'hDC;
  localparam logic [7:0] KISS_TFESC = 8'hDD;
  localparam logic [7:0] KISS_CMD_DATA = 8'h00;

  // job kinds handed from front to back
  localparam logic [3:0] OP_CHAR    = 4'd0;  // one character as is
  localparam logic [3:0] OP_ADDRC   = 4'd1;  // address char (shift, drop space)
  localparam logic [3:0] OP_HDR13   = 4'd2;  // src ssid, '>', dest, maybe ':'
  localparam logic [3:0] OP_RELAY   = 4'd3;  // ',' relay, maybe ':'
  localparam logic [3:0] OP_END     = 4'd4;  // bare end marker
  localparam logic [3:0] OP_ENDWIN  = 4'd5;  // ':' + window bytes + marker
  localparam logic [3:0] OP_RAW2    = 4'd6;  // FEND + command raw
  localparam logic [3:0] OP_RAWCH   = 4'd7;  // one raw byte
  localparam logic [3:0] OP_RAWEND  = 4'd8;  // raw closing byte

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  b;
    logic [2:0]  fill;     // relay fill for end window
    logic        shrt;
    logic        bad;
    logic [55:0] addr;     // dest or relay snapshot, byte 0 lowest
  } job_t;

  function automatic logic [7:0] ssid_digit(input logic [3:0] s, input logic second);
    logic [7:0] r;
    if (s >= 4'd10) r = second ? (8'h30 + {4'd0, s} - 8'd10) : 8'h31;
    else r = 8'h30 + {4'd0, s};
    return r;
  endfunction
endpackage

>>> design/kft_front.sv
module kft_front #(
  parameter int MAX_FRAME_BYTES = kft_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [7:0] in_byte,
  input  logic in_end,
  output logic in_ready,
  output logic job_valid,
  output kft_pkg::job_t job,
  input  logic job_ready
);
  import kft_pkg::*;
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PW-1:0] pos_r;
  logic [1:0] mode_r;
  logic esc_r, hdr_r, disc_r;
  logic [2:0] fill_r;
  logic [1:0] skip_r;
  logic [7:0] dest_r [7];
  logic [7:0] rel_r [7];

  logic go, body, emit;
  logic [7:0] bb;
  job_t j;
  logic [55:0] dpack, rpack;

  assign in_ready = job_ready;
  assign go = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      dpack[i*8 +: 8] = dest_r[i];
      rpack[i*8 +: 8] = rel_r[i];
    end
  end

  always_comb begin
    body = 1'b0;
    bb = in_byte;
    if (mode_r == 2'd2 && !disc_r && !in_end) begin
      if (esc_r) begin
        body = (in_byte == KISS_TFEND) || (in_byte == KISS_TFESC);
        bb = (in_byte == KISS_TFEND) ? KISS_FEND : KISS_FESC;
      end else begin
        body = in_byte != KISS_FESC;
      end
    end
    if (body && pos_r >= PW'(MAX_FRAME_BYTES)) body = 1'b0;
  end

  always_comb begin
    emit = 1'b0;
    j = '0;
    j.b = bb;
    j.fill = fill_r;
    if (mode_r == 2'd0 && !disc_r) begin
      emit = in_end;
      j.op = OP_END;
      j.shrt = in_byte == KISS_FEND;
      j.bad = in_byte != KISS_FEND;
    end else if (in_end) begin
      emit = 1'b1;
      j.op = OP_END;
      if (disc_r) j.bad = 1'b1;
      else if (mode_r == 2'd1) j.shrt = 1'b1;
      else if (mode_r == 2'd2) begin
        j.shrt = pos_r < PW'(16);
        j.addr = rpack;
        if (!hdr_r && pos_r >= PW'(14)) j.op = OP_ENDWIN;
      end else begin
        j.op = OP_RAWEND;
        j.b = in_byte;
      end
    end else if (!disc_r) begin
      if (mode_r == 2'd1) begin
        emit = in_byte != KISS_CMD_DATA;
        j.op = OP_RAW2;
        j.b = in_byte;
      end else if (mode_r == 2'd3) begin
        emit = 1'b1;
        j.op = OP_RAWCH;
        j.b = in_byte;
      end else if (body) begin
        if (hdr_r) begin
          emit = skip_r == 2'd0;
          j.op = OP_CHAR;
        end else if (pos_r < PW'(7)) begin
          emit = 1'b0;
        end else if (pos_r < PW'(13)) begin
          emit = 1'b1;
          j.op = OP_ADDRC;
        end else if (pos_r == PW'(13)) begin
          emit = 1'b1;
          j.op = OP_HDR13;
          j.addr = dpack;
        end else if (fill_r == 3'd7) begin
          emit = 1'b1;
          j.op = OP_RELAY;
          j.addr = rpack;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid <= 1'b0;
    end else if (job_ready) begin
      job_valid <= go && emit;
    end
    if (job_ready) job <= j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; mode_r <= '0; esc_r <= 1'b0; hdr_r <= 1'b0;
      disc_r <= 1'b0; fill_r <= '0; skip_r <= '0;
    end else if (go) begin
      if (mode_r == 2'd0 && !disc_r && !in_end) begin
        if (in_byte == KISS_FEND) mode_r <= 2'd1;
        else disc_r <= 1'b1;
      end else if (in_end) begin
        pos_r <= '0; mode_r <= '0; esc_r <= 1'b0; hdr_r <= 1'b0;
        disc_r <= 1'b0; fill_r <= '0; skip_r <= '0;
      end else if (!disc_r) begin
        if (mode_r == 2'd1) begin
          mode_r <= (in_byte == KISS_CMD_DATA) ? 2'd2 : 2'd3;
        end else if (mode_r == 2'd2) begin
          if (esc_r) esc_r <= 1'b0;
          else if (in_byte == KISS_FESC) esc_r <= 1'b1;
          if (body) begin
            pos_r <= pos_r + PW'(1);
            if (hdr_r) begin
              if (skip_r != 2'd0) skip_r <= skip_r - 2'd1;
            end else if (pos_r < PW'(7)) begin
              dest_r[pos_r[2:0]] <= bb;
            end else if (pos_r == PW'(13)) begin
              fill_r <= '0;
              if (bb[0]) begin hdr_r <= 1'b1; skip_r <= 2'd2; end
            end else if (pos_r > PW'(13)) begin
              if (fill_r != 3'd7) begin
                rel_r[fill_r] <= bb;
                fill_r <= fill_r + 3'd1;
              end else if (rel_r[6][0]) begin
                hdr_r <= 1'b1; skip_r <= 2'd1;
              end else begin
                rel_r[0] <= bb;
                fill_r <= 3'd1;
              end
            end
          end
        end
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n) hdr_r |-> skip_r != 2'd3)
    else $error("skip count out of range");
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> mode_r == 2'd0) else $error("discard outside start mode");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |=> job_valid && $stable(job)) else $error("job lost");
endmodule

>>> design/kft_queue.sv
module kft_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  kft_pkg::job_t wr_job,
  output logic wr_ready,
  output logic rd_valid,
  output kft_pkg::job_t rd_job,
  input  logic rd_ready
);
  import kft_pkg::*;
  job_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic w, r;

  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_job = mem_r[rp_r];
  assign w = wr_valid && wr_ready;
  assign r = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (w) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (w) wp_r <= wp_r + 2'd1;
      if (r) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, w} - {2'd0, r};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("queue count overflow");
endmodule

>>> design/kft_back.sv
module kft_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  input  kft_pkg::job_t job,
  output logic job_ready,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [7:0] out_tdata,
  output logic out_tlast,
  output logic [3:0] out_tuser
);
  import kft_pkg::*;
  // step counter walks the character slots of one job
  logic [4:0] step_r;
  logic busy_r;
  logic [7:0] ch;
  logic has, last, done, raw, shrt, bad, skip;
  logic [7:0] ab;
  logic [3:0] sid;
  logic take;

  function automatic logic [7:0] abyte(input logic [55:0] a, input logic [2:0] i);
    return a[i*8 +: 8];
  endfunction

  // address slots: 0..5 chars, 6 '-', 7 digit1, 8 digit2, 9 '*'
  always_comb begin
    ch = 8'h00; has = 1'b1; last = 1'b0; raw = 1'b0; shrt = 1'b0; bad = 1'b0;
    skip = 1'b0; done = 1'b0; ab = 8'h00; sid = job.addr[52:49];
    case (job.op)
      OP_CHAR: begin ch = job.b; done = 1'b1; end
      OP_ADDRC: begin ch = {1'b0, job.b[7:1]}; skip = ch == 8'h20; done = 1'b1; end
      OP_HDR13, OP_RELAY: begin
        // HDR13: 0..3 src ssid, 4 '>', 5..14 dest, 15 ':'
        // RELAY: 0 ',', 1..10 relay, 11 ':'
        logic [4:0] k;
        logic [3:0] s;
        k = 5'd0;
        s = 4'd0;
        if (job.op == OP_HDR13 && step_r < 5'd4) begin
          s = job.b[4:1];
          case (step_r[1:0])
            2'd0: begin ch = 8'h2D; skip = s == 4'd0; end
            2'd1: begin ch = ssid_digit(s, 1'b0); skip = s == 4'd0; end
            2'd2: begin ch = ssid_digit(s, 1'b1); skip = s < 4'd10; end
            default: skip = 1'b1;
          endcase
        end else if (job.op == OP_HDR13 && step_r == 5'd4) ch = 8'h3E;
        else if (job.op == OP_RELAY && step_r == 5'd0) ch = 8'h2C;
        else begin
          s = sid;
          k = step_r - ((job.op == OP_HDR13) ? 5'd5 : 5'd1);
          if (k < 5'd6) begin
            ab = abyte(job.addr, k[2:0]);
            ch = {1'b0, ab[7:1]}; skip = ch == 8'h20;
          end else if (k == 5'd6) begin ch = 8'h2D; skip = s == 4'd0; end
          else if (k == 5'd7) begin ch = ssid_digit(s, 1'b0); skip = s == 4'd0; end
          else if (k == 5'd8) begin ch = ssid_digit(s, 1'b1); skip = s < 4'd10; end
          else if (k == 5'd9) begin
            ch = 8'h2A; skip = !(job.op == OP_RELAY && job.addr[55]);
          end else begin
            ch = 8'h3A;
            skip = (job.op == OP_HDR13) ? !job.b[0] : !job.addr[48];
            done = 1'b1;
          end
        end
      end
      OP_ENDWIN: begin
        if (step_r == 5'd0) ch = 8'h3A;
        else if (step_r < 5'd6) begin
          ch = abyte(job.addr, 3'(step_r + 5'd1));
          skip = step_r + 5'd1 >= {2'd0, job.fill};
        end else begin
          ch = 8'h00; has = 1'b0; last = 1'b1; shrt = job.shrt; done = 1'b1;
        end
      end
      OP_RAW2: begin
        raw = 1'b1; ch = (step_r == 5'd0) ? KISS_FEND : job.b; done = step_r != 5'd0;
      end
      OP_RAWCH: begin raw = 1'b1; ch = job.b; done = 1'b1; end
      OP_RAWEND: begin raw = 1'b1; ch = job.b; last = 1'b1; done = 1'b1; end
      default: begin
        ch = 8'h00; has = 1'b0; last = 1'b1; shrt = job.shrt; bad = job.bad;
        done = 1'b1;
      end
    endcase
  end

  // skid-free output register: load when empty or taken
  assign take = job_valid && (!out_tvalid || out_tready);
  assign job_ready = take && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0; step_r <= '0; busy_r <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (take) begin
        if (!skip) out_tvalid <= 1'b1;
        step_r <= done ? 5'd0 : step_r + 5'd1;
        busy_r <= !done;
      end
    end
    if (take && !skip) begin
      out_tdata <= ch;
      out_tlast <= last;
      out_tuser <= {bad, shrt, raw, has};
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r != 5'd0) else $error("step reset while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[3:2] == 2'b00) else $error("flags off end");
endmodule

>>> design/kiss_frame_to_tnc2_text.sv
// KISS frame bytes in, TNC2 monitor text out. The front end takes one byte per
// cycle, unescapes and classifies it, and hands a job to a four-entry queue;
// the back end spells each job out at most one character per cycle, stalling on
// out_tready. A header byte that releases the destination spells ssid, '>', dest.
// Input stalls only when the queue is full. tuser flags are valid on tlast.
module kiss_frame_to_tnc2_text #(
  parameter int MAX_FRAME_BYTES = kft_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,   // frame_byte
  input  logic in_tlast,         // frame_end
  output logic out_tvalid,
  input  logic out_tready,
  output logic [7:0] out_tdata,  // text_byte
  output logic out_tlast,        // end_of_text
  output logic [3:0] out_tuser   // bit 0 has_char, 1 raw_passthrough, 2 short_frame, 3 bad_frame
);
  import kft_pkg::*;
  job_t fj, qj;
  logic fv, fr, qv, qr;

  kft_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_byte(in_tdata), .in_end(in_tlast),
    .in_ready(in_tready), .job_valid(fv), .job(fj), .job_ready(fr));

  kft_queue u_queue (.clk, .rst_n, .wr_valid(fv), .wr_job(fj), .wr_ready(fr),
    .rd_valid(qv), .rd_job(qj), .rd_ready(qr));

  kft_back u_back (.clk, .rst_n, .job_valid(qv), .job(qj), .job_ready(qr),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser);
endmodule
